// ----- hdl/assert_macros.svh -----
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nfdm_pkg.sv -----
// types, constants and command codes of the nand flash device model
package nfdm_pkg;

    localparam int NUM_PAGES_DEF = 256;
    localparam int BLOCK_PAGES   = 32;
    localparam int PAGE_BYTES    = 528;
    localparam int SPARE_BYTES   = 16;
    localparam int ERASE_BYTES   = BLOCK_PAGES * PAGE_BYTES;

    // linear byte addresses: 17-bit page times 528 plus column and read count
    localparam int LIN_W  = 28;
    localparam int PAGE_W = 17;
    localparam int PB_AW  = $clog2(PAGE_BYTES);
    localparam int DCNT_W = 10;
    localparam int RCNT_W = 20;
    localparam int ACNT_W = 3;

    localparam logic [RCNT_W-1:0] READ_MAX = '1;
    localparam logic [DCNT_W-1:0] DCNT_MAX = '1;

    // command bytes
    localparam logic [7:0] CMD_READ0  = 8'h00;
    localparam logic [7:0] CMD_READ1  = 8'h01;
    localparam logic [7:0] CMD_SPARE  = 8'h50;
    localparam logic [7:0] CMD_ERASE1 = 8'h60;
    localparam logic [7:0] CMD_ERASE2 = 8'hD0;
    localparam logic [7:0] CMD_STATUS = 8'h70;
    localparam logic [7:0] CMD_ID     = 8'h90;
    localparam logic [7:0] CMD_PROG1  = 8'h80;
    localparam logic [7:0] CMD_PROG2  = 8'h10;
    localparam logic [7:0] CMD_RESET  = 8'hFF;

    // bytes returned on the data port
    localparam logic [7:0] STATUS_READY = 8'h40;
    localparam logic [7:0] ID_MAKER     = 8'hEC;
    localparam logic [7:0] ID_DEVICE    = 8'h75;
    localparam logic [7:0] BYTE_ERASED  = 8'hFF;

    // configuration register indexes
    localparam logic CFG_PIN_LAYOUT = 1'b0;
    localparam logic CFG_OVERWRITE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NOCMD = 3'd1,
        ST_SEQ   = 3'd2,
        ST_BOTH  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_READ,
        K_PROG,
        K_ERASE
    } t_kind;

    typedef struct packed {
        logic load;
        logic clr_init;
        logic decode;
        logic calc;
        logic check;
        logic step;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        t_kind dec_kind;
        t_kind kind;
        logic  in_range;
        logic  last;
    } t_dp_stat;

endpackage

// ----- hdl/nfdm_ctrl.sv -----
// controller state machine: sequences decode, address check, array sweeps and response
module nfdm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  nfdm_pkg::t_dp_stat i_stat,
    output nfdm_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    typedef enum logic [3:0] {
        S_CINIT,
        S_CLR,
        S_IDLE,
        S_DEC,
        S_CALC,
        S_CHK,
        S_RD,
        S_SWP,
        S_DRAIN,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CINIT: n_state = S_CLR;
            S_CLR: begin
                if (i_stat.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = (i_stat.dec_kind == nfdm_pkg::K_SIMPLE) ? S_RESP : S_CALC;
            end
            S_CALC: n_state = S_CHK;
            S_CHK: begin
                if (!i_stat.in_range) n_state = S_RESP;
                else if (i_stat.kind == nfdm_pkg::K_READ) n_state = S_RD;
                else n_state = S_SWP;
            end
            S_RD: n_state = S_RESP;
            S_SWP: begin
                if (i_stat.last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.clr_init = (r_state == S_CINIT);
        o_cmd.decode   = (r_state == S_DEC);
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.check    = (r_state == S_CHK);
        o_cmd.step     = (r_state == S_SWP) || (r_state == S_CLR);
        o_cmd.respond  = (r_state == S_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CINIT;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state == S_RESP);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ----- hdl/nfdm_dp.sv -----
// datapath: latch and sequence registers, decode, address maths, page buffer and flash array
module nfdm_dp #(
    parameter int NUM_PAGES = nfdm_pkg::NUM_PAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic               i_cfg_data,
    input  logic               i_op,
    input  logic [7:0]         i_ctrl_byte,
    input  logic [7:0]         i_value,
    input  nfdm_pkg::t_dp_cmd  i_cmd,
    output nfdm_pkg::t_dp_stat o_stat,
    output logic [7:0]         o_read_data,
    output logic [2:0]         o_status
);

    localparam int ARRAY_BYTES = NUM_PAGES * nfdm_pkg::PAGE_BYTES;
    localparam int AW          = $clog2(ARRAY_BYTES);
    localparam int LW          = nfdm_pkg::LIN_W;
    localparam logic [LW:0] ARRAY_END = (LW+1)'(ARRAY_BYTES);

    // configuration
    logic r_pin_layout;
    logic r_overwrite;

    // latched item
    logic       r_op;
    logic [7:0] r_ctrl;
    logic [7:0] r_value;

    // sequence state
    logic [7:0]                    r_cmd_first, n_cmd_first;
    logic [7:0]                    r_cmd_second, n_cmd_second;
    logic [1:0]                    r_cmd_count, n_cmd_count;
    logic [3:0][7:0]               r_addr_b, n_addr_b;
    logic [nfdm_pkg::ACNT_W-1:0]   r_addr_count, n_addr_count;
    logic [nfdm_pkg::DCNT_W-1:0]   r_data_count, n_data_count;
    logic [nfdm_pkg::RCNT_W-1:0]   r_read_count, n_read_count;

    // decode results
    nfdm_pkg::t_kind              d_kind;
    nfdm_pkg::t_status            d_status;
    logic [7:0]                   d_data;
    logic [nfdm_pkg::PAGE_W-1:0]  d_page;
    logic [LW-1:0]                d_off;
    logic [LW-1:0]                d_len;
    logic                         pb_we;
    logic                         do_clr;
    logic                         set_cmd;
    logic                         cle;
    logic                         ale;
    logic                         seq_ok;
    logic                         lim_ok;
    logic [nfdm_pkg::DCNT_W-1:0]  lim;
    logic [nfdm_pkg::DCNT_W-1:0]  dc_inc;
    logic [9:0]                   col;
    logic [nfdm_pkg::PAGE_W-1:0]  pg_rw;
    logic [nfdm_pkg::PAGE_W-1:0]  pg_blk;

    // registered operation
    nfdm_pkg::t_kind   r_kind;
    nfdm_pkg::t_status r_status;
    logic [7:0]        r_data;
    logic [LW-1:0]     r_base;
    logic [LW-1:0]     r_off;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_addr;
    logic              r_in_range;
    logic              in_range;

    // sweep
    logic [LW-1:0]              r_ptr;
    logic [LW-1:0]              r_left;
    logic [nfdm_pkg::PB_AW-1:0] r_pidx;
    logic                       r_fill;
    logic                       r_pw;
    logic [AW-1:0]              r_pwa;

    // memories
    logic [7:0] flash_mem [ARRAY_BYTES];
    logic [7:0] pbuf_mem  [nfdm_pkg::PAGE_BYTES];
    logic [7:0] r_mem_rd;
    logic [7:0] r_pb_rd;
    logic       mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [7:0] mem_wd;
    logic [7:0] cur;

    logic [7:0] r_out_data;
    logic [2:0] r_out_status;

    function automatic logic [nfdm_pkg::DCNT_W-1:0] DCNT_W_SPARE();
        return nfdm_pkg::DCNT_W'(nfdm_pkg::SPARE_BYTES);
    endfunction

    function automatic logic [nfdm_pkg::DCNT_W-1:0] DCNT_W_PAGE();
        return nfdm_pkg::DCNT_W'(nfdm_pkg::PAGE_BYTES);
    endfunction

    assign cle = r_pin_layout ? r_ctrl[5] : r_ctrl[0];
    assign ale = r_pin_layout ? r_ctrl[4] : r_ctrl[1];
    assign pg_rw  = {r_addr_b[3][0], r_addr_b[2], r_addr_b[1]};
    assign pg_blk = {r_addr_b[2][0], r_addr_b[1], r_addr_b[0]}
                    & ~(nfdm_pkg::PAGE_W)'(nfdm_pkg::BLOCK_PAGES - 1);
    assign dc_inc = (r_data_count != nfdm_pkg::DCNT_MAX) ? r_data_count + 1'b1
                                                         : r_data_count;

    always_comb begin
        n_cmd_first  = r_cmd_first;
        n_cmd_second = r_cmd_second;
        n_cmd_count  = r_cmd_count;
        n_addr_b     = r_addr_b;
        n_addr_count = r_addr_count;
        n_data_count = r_data_count;
        n_read_count = r_read_count;
        d_kind   = nfdm_pkg::K_SIMPLE;
        d_status = nfdm_pkg::ST_OK;
        d_data   = r_op ? 8'h00 : nfdm_pkg::BYTE_ERASED;
        d_page   = '0;
        d_off    = '0;
        d_len    = '0;
        pb_we    = 1'b0;
        do_clr   = 1'b0;
        set_cmd  = 1'b0;
        seq_ok   = 1'b0;
        lim_ok   = 1'b0;
        lim      = '0;
        col      = {2'b00, r_addr_b[0]};
        if (!r_op) begin
            if (r_cmd_count == 2'd0) begin
                d_status = nfdm_pkg::ST_NOCMD;
            end else if (r_cmd_first == nfdm_pkg::CMD_STATUS && r_cmd_count == 2'd1 &&
                         r_addr_count == '0 && r_data_count == '0) begin
                do_clr = 1'b1;
                d_data = nfdm_pkg::STATUS_READY;
            end else if (r_cmd_first == nfdm_pkg::CMD_ID && r_cmd_count == 2'd1 &&
                         r_addr_count == 3'd1 && r_addr_b[0] == 8'h00 &&
                         r_data_count == '0) begin
                if (r_read_count == '0) begin
                    n_read_count = 20'd1;
                    d_data = nfdm_pkg::ID_MAKER;
                end else if (r_read_count == 20'd1) begin
                    do_clr = 1'b1;
                    d_data = nfdm_pkg::ID_DEVICE;
                end else begin
                    d_status = nfdm_pkg::ST_SEQ;
                end
            end else if (r_cmd_first inside {nfdm_pkg::CMD_READ0, nfdm_pkg::CMD_READ1,
                                             nfdm_pkg::CMD_SPARE}) begin
                if (r_cmd_count != 2'd1 || r_addr_count != 3'd4 || r_data_count != '0) begin
                    d_status = nfdm_pkg::ST_SEQ;
                end else begin
                    if (r_cmd_first == nfdm_pkg::CMD_READ1) col = col + 10'd256;
                    if (r_cmd_first == nfdm_pkg::CMD_SPARE) col = col + 10'd512;
                    d_kind = nfdm_pkg::K_READ;
                    d_page = pg_rw;
                    d_off  = LW'(col) + LW'(r_read_count);
                    d_len  = LW'(1);
                    if (r_read_count != nfdm_pkg::READ_MAX) n_read_count = r_read_count + 1'b1;
                end
            end else begin
                d_status = nfdm_pkg::ST_SEQ;
            end
        end else if (cle && ale) begin
            d_status = nfdm_pkg::ST_BOTH;
        end else if (cle) begin
            if (r_value inside {nfdm_pkg::CMD_RESET, nfdm_pkg::CMD_READ0, nfdm_pkg::CMD_READ1,
                                nfdm_pkg::CMD_SPARE, nfdm_pkg::CMD_ERASE1,
                                nfdm_pkg::CMD_STATUS, nfdm_pkg::CMD_ID}) begin
                // a finished read or erase may be abandoned without complaint
                if (r_cmd_count == 2'd1 && r_addr_count == 3'd4 && r_data_count == '0 &&
                    r_cmd_first inside {nfdm_pkg::CMD_READ0, nfdm_pkg::CMD_READ1,
                                        nfdm_pkg::CMD_SPARE})
                    seq_ok = 1'b1;
                if (r_cmd_count == 2'd2 && r_addr_count == 3'd3 && r_data_count == '0 &&
                    r_cmd_first == nfdm_pkg::CMD_ERASE1)
                    seq_ok = 1'b1;
                if (r_cmd_count != 2'd0 && !seq_ok) d_status = nfdm_pkg::ST_SEQ;
                do_clr  = 1'b1;
                set_cmd = (r_value != nfdm_pkg::CMD_RESET);
            end else if (r_value == nfdm_pkg::CMD_PROG2) begin
                if (r_cmd_count == 2'd2 && r_cmd_second == nfdm_pkg::CMD_PROG1 &&
                    r_addr_count == 3'd4 &&
                    ((r_cmd_first == nfdm_pkg::CMD_SPARE &&
                      r_data_count == DCNT_W_SPARE()) ||
                     (r_cmd_first == nfdm_pkg::CMD_READ0 &&
                      r_data_count == DCNT_W_PAGE()))) begin
                    d_kind = nfdm_pkg::K_PROG;
                    d_page = pg_rw;
                    if (r_cmd_first == nfdm_pkg::CMD_SPARE) begin
                        d_off = LW'(col) + LW'(512);
                        d_len = LW'(nfdm_pkg::SPARE_BYTES);
                    end else begin
                        d_off = LW'(col);
                        d_len = LW'(nfdm_pkg::PAGE_BYTES);
                    end
                    do_clr = 1'b1;
                end else begin
                    d_status = nfdm_pkg::ST_SEQ;
                end
            end else if (r_value == nfdm_pkg::CMD_ERASE2) begin
                if (r_cmd_count != 2'd1 || r_cmd_first != nfdm_pkg::CMD_ERASE1 ||
                    r_addr_count != 3'd3 || r_data_count != '0) begin
                    d_status = nfdm_pkg::ST_SEQ;
                end else begin
                    d_kind = nfdm_pkg::K_ERASE;
                    d_page = pg_blk;
                    d_len  = LW'(nfdm_pkg::ERASE_BYTES);
                    if (r_read_count != nfdm_pkg::READ_MAX) n_read_count = r_read_count + 1'b1;
                    n_cmd_second = nfdm_pkg::CMD_ERASE2;
                    n_cmd_count  = 2'd2;
                end
            end else if (r_value == nfdm_pkg::CMD_PROG1) begin
                if (r_cmd_count != 2'd1 || r_addr_count != '0 || r_data_count != '0 ||
                    (r_cmd_first != nfdm_pkg::CMD_SPARE &&
                     r_cmd_first != nfdm_pkg::CMD_READ0)) begin
                    d_status = nfdm_pkg::ST_SEQ;
                end else begin
                    n_cmd_second = nfdm_pkg::CMD_PROG1;
                    n_cmd_count  = 2'd2;
                end
            end else begin
                d_status = nfdm_pkg::ST_SEQ;
            end
        end else if (ale) begin
            if (r_cmd_count == 2'd0) begin
                d_status = nfdm_pkg::ST_NOCMD;
            end else if (r_addr_count < 3'd4) begin
                n_addr_b[r_addr_count[1:0]] = r_value;
                n_addr_count = r_addr_count + 1'b1;
            end else begin
                if (r_addr_count != 3'd7) n_addr_count = r_addr_count + 1'b1;
                d_status = nfdm_pkg::ST_SEQ;
            end
        end else begin
            if (r_cmd_count == 2'd0) begin
                d_status = nfdm_pkg::ST_NOCMD;
            end else if (r_cmd_count != 2'd2 || r_cmd_second != nfdm_pkg::CMD_PROG1) begin
                d_status = nfdm_pkg::ST_SEQ;
            end else begin
                if (r_cmd_first == nfdm_pkg::CMD_SPARE) begin
                    lim = DCNT_W_SPARE();
                    lim_ok = 1'b1;
                end else if (r_cmd_first == nfdm_pkg::CMD_READ0) begin
                    lim = DCNT_W_PAGE();
                    lim_ok = 1'b1;
                end
                if (!lim_ok) begin
                    d_status = nfdm_pkg::ST_SEQ;
                end else begin
                    pb_we = (r_data_count < DCNT_W_PAGE());
                    n_data_count = dc_inc;
                    if (dc_inc > lim) d_status = nfdm_pkg::ST_SEQ;
                end
            end
        end
        if (do_clr) begin
            n_cmd_first  = '0;
            n_cmd_second = '0;
            n_cmd_count  = '0;
            n_addr_b     = '0;
            n_addr_count = '0;
            n_data_count = '0;
            n_read_count = '0;
        end
        if (set_cmd) begin
            n_cmd_first = r_value;
            n_cmd_count = 2'd1;
        end
    end

    assign in_range = ({1'b0, r_addr} + {1'b0, r_len}) <= ARRAY_END;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_layout <= 1'b0;
            r_overwrite  <= 1'b0;
            r_cmd_first  <= '0;
            r_cmd_second <= '0;
            r_cmd_count  <= '0;
            r_addr_b     <= '0;
            r_addr_count <= '0;
            r_data_count <= '0;
            r_read_count <= '0;
            r_kind       <= nfdm_pkg::K_SIMPLE;
            r_fill       <= 1'b0;
            r_pw         <= 1'b0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nfdm_pkg::CFG_PIN_LAYOUT: r_pin_layout <= i_cfg_data;
                    nfdm_pkg::CFG_OVERWRITE:  r_overwrite  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.decode) begin
                r_cmd_first  <= n_cmd_first;
                r_cmd_second <= n_cmd_second;
                r_cmd_count  <= n_cmd_count;
                r_addr_b     <= n_addr_b;
                r_addr_count <= n_addr_count;
                r_data_count <= n_data_count;
                r_read_count <= n_read_count;
                r_kind       <= d_kind;
            end
            if (i_cmd.clr_init) begin
                r_left <= LW'(ARRAY_BYTES);
                r_fill <= 1'b1;
            end else if (i_cmd.check) begin
                r_left <= r_len;
                r_fill <= (r_kind == nfdm_pkg::K_ERASE);
            end else if (i_cmd.step) begin
                r_left <= r_left - 1'b1;
            end
            // program writes land in the cycle after their reads
            r_pw <= i_cmd.step && !r_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_ctrl  <= i_ctrl_byte;
            r_value <= i_value;
        end
        if (i_cmd.decode) begin
            r_status <= d_status;
            r_data   <= d_data;
            r_base   <= LW'(d_page) * LW'(nfdm_pkg::PAGE_BYTES);
            r_off    <= d_off;
            r_len    <= d_len;
        end
        if (i_cmd.calc) r_addr <= r_base + r_off;
        if (i_cmd.clr_init) begin
            r_ptr  <= '0;
            r_pidx <= '0;
        end else if (i_cmd.check) begin
            r_ptr      <= r_addr;
            r_pidx     <= '0;
            r_in_range <= in_range;
        end else if (i_cmd.step) begin
            r_ptr  <= r_ptr + 1'b1;
            r_pidx <= r_pidx + 1'b1;
        end
        r_pwa <= r_ptr[AW-1:0];
        if (i_cmd.respond) begin
            r_out_data <= (r_kind == nfdm_pkg::K_READ && r_in_range) ? r_mem_rd : r_data;
            r_out_status <= (r_kind != nfdm_pkg::K_SIMPLE && !r_in_range)
                            ? nfdm_pkg::ST_RANGE : r_status;
        end
    end

    // merge of existing and buffered bytes
    always_comb begin
        cur = r_mem_rd;
        if (cur != nfdm_pkg::BYTE_ERASED && r_overwrite) cur = nfdm_pkg::BYTE_ERASED;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr[AW-1:0];
        mem_wd = nfdm_pkg::BYTE_ERASED;
        if (i_cmd.step && r_fill) begin
            mem_we = 1'b1;
        end else if (r_pw) begin
            mem_we = 1'b1;
            mem_wa = r_pwa;
            mem_wd = cur & r_pb_rd;
        end
    end

    assign mem_ra = i_cmd.step ? r_ptr[AW-1:0] : r_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) flash_mem[mem_wa] <= mem_wd;
        r_mem_rd <= flash_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && pb_we) pbuf_mem[r_data_count[nfdm_pkg::PB_AW-1:0]] <= r_value;
        r_pb_rd <= pbuf_mem[r_pidx];
    end

    assign o_stat.dec_kind = d_kind;
    assign o_stat.kind     = r_kind;
    assign o_stat.in_range = in_range;
    assign o_stat.last     = (r_left == LW'(1));
    assign o_read_data     = r_out_data;
    assign o_status        = r_out_status;

endmodule

// ----- hdl/nand_flash_device_model_unit.sv -----
// top level of the small-page nand flash device model
//
// channels: an item (i_op, i_ctrl_byte, i_value) is taken at a rising edge with
// start high and busy low. each item gives one result (o_read_data, o_status),
// shown for exactly one cycle with o_done high; the receiver cannot stall it.
// configuration: i_cfg_we with i_cfg_idx (0 pin layout, 1 overwrite unerased)
// and i_cfg_data, written at once, taken at any time.
// sequencing: an item that only touches the sequence registers passes S_DEC and
// S_RESP; o_done rises and busy falls in the same cycle, so the next such item
// is taken only after the last one's result. an array read passes page multiply,
// address add, range check and a registered memory read. program walks 16 or 528
// bytes, erase 16896 bytes, one byte per cycle through the single array write port,
// between set-up and drain states.
// reset: synchronous, active low. after it the array is swept to 0xff one byte
// a cycle, over all NUM_PAGES*528 bytes, with busy high; configuration writes
// are taken during the sweep.
module nand_flash_device_model_unit #(
    parameter int NUM_PAGES = nfdm_pkg::NUM_PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [7:0] i_ctrl_byte,
    input  logic [7:0] i_value,
    output logic       o_done,
    output logic [7:0] o_read_data,
    output logic [2:0] o_status
);

    nfdm_pkg::t_dp_cmd  dp_cmd;
    nfdm_pkg::t_dp_stat dp_stat;

    nfdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    nfdm_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_ctrl_byte (i_ctrl_byte),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

endmodule

// ----- hdl/nfdm_chk.sv -----
// port checker for the nand flash device model, bound to the top level
`include "assert_macros.svh"

module nfdm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [2:0] o_status
);

    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after item")
    `CHK_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `CHK_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result held over two cycles")
    `CHK_IMPLY(a_status_code, i_clk, i_rst_n, o_done, o_status <= 3'd4, "status code unknown")

endmodule

bind nand_flash_device_model_unit nfdm_chk u_nfdm_chk (.*);
